// ===== hdl/pointer_accel_cursor_clamp_assert.svh =====
// assertion macros for the pointer acceleration and cursor clamp block
// expects clk and rst in the scope of each use
`ifndef POINTER_ACCEL_CURSOR_CLAMP_ASSERT_SVH
`define POINTER_ACCEL_CURSOR_CLAMP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pac_pkg.sv =====
// shared types, codes and constants of the pointer acceleration block
// used by pac_regs, pac_div and pointer_accel_cursor_clamp
package pac_pkg;

  // field widths
  localparam int COORD_W  = 16;
  localparam int ID_W     = 16;
  localparam int NUM_W    = 8;
  localparam int THR_W    = 15;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // magnitude of a delta, product and scaled delta widths
  localparam int MAG_W    = COORD_W + 1;
  localparam int DIVD_W   = 24;
  localparam int DELTA_W  = DIVD_W + 1;
  localparam int TARGET_W = DELTA_W + 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  // mode bits and border flag bits
  localparam int MODE_CONFINED = 0;
  localparam int MODE_HW       = 1;
  localparam int FLAG_X = 0;
  localparam int FLAG_Y = 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_NUM = 4'd0,
    REG_ACCEL_DEN = 4'd1,
    REG_ACCEL_THR = 4'd2,
    REG_X_MIN     = 4'd3,
    REG_X_MAX     = 4'd4,
    REG_Y_MIN     = 4'd5,
    REG_Y_MAX     = 4'd6,
    REG_MODE      = 4'd7
  } reg_idx_t;

  // input kinds
  typedef enum logic [1:0] {
    IK_X_DELTA = 2'd0,
    IK_Y_DELTA = 2'd1,
    IK_OTHER   = 2'd2,
    IK_SET_POS = 2'd3
  } in_kind_t;

  // result kinds
  typedef enum logic [2:0] {
    OK_X_ABS  = 3'd0,
    OK_Y_ABS  = 3'd1,
    OK_X_ZERO = 3'd2,
    OK_Y_ZERO = 3'd3,
    OK_OTHER  = 3'd4
  } out_kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_BOUND,
    ST_EMIT,
    ST_SET_Y
  } state_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [NUM_W-1:0]          accel_num;
    logic [NUM_W-1:0]          accel_den;
    logic [THR_W-1:0]          accel_thr;
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] y_max;
    logic [MODE_W-1:0]         mode;
    logic                      limits_wr;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic [2:0]                out_kind;
    logic [ID_W-1:0]           out_id;
    logic signed [COORD_W-1:0] out_value;
    logic                      update_cursor;
    logic                      last;
  } res_t;

endpackage

// ===== hdl/pointer_accel_cursor_clamp.sv =====
// Pointer acceleration and cursor clamp, top level with sequencer and cursor datapath
// depends on pac_pkg, pac_regs, pac_div and pointer_accel_cursor_clamp_assert.svh
//
// One input beat is taken at a time; in_stall stays high until its results have been
// handed to the output register. From the accept cycle until in_stall drops again,
// an other event passes through capture and output load. A delta at or below the
// threshold passes through capture, bound step and output load; a dropped delta ends
// after the bound step. A set position has its x beat loaded, then its second beat
// formed and loaded. A delta above the threshold adds a multiply step, a divider
// start step and the serial divider, which yields one quotient bit per cycle over 24
// bits and then raises done. A result that waits in the output register under
// out_stall holds back the output load of the item behind it. The output register
// lets a result wait for out_stall to drop while the next beat is accepted.
module pointer_accel_cursor_clamp (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_write,
  input  logic [pac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pac_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       kind,
  input  logic [pac_pkg::ID_W-1:0]         event_id,
  input  logic signed [pac_pkg::COORD_W-1:0] value,
  input  logic signed [pac_pkg::COORD_W-1:0] pos_x,
  input  logic signed [pac_pkg::COORD_W-1:0] pos_y,
  // output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_kind,
  output logic [pac_pkg::ID_W-1:0]         out_id,
  output logic signed [pac_pkg::COORD_W-1:0] out_value,
  output logic                             update_cursor,
  output logic                             last
);

  `include "pointer_accel_cursor_clamp_assert.svh"

  pac_pkg::cfg_t   cfg;
  pac_pkg::state_t state;
  pac_pkg::state_t state_next;

  logic in_acc;
  logic out_acc;
  logic out_free;
  logic div_start;
  logic div_done;
  logic emit_load;
  logic [pac_pkg::DIVD_W-1:0] div_q;

  // item registers
  logic [1:0]                         kind_reg;
  logic                               val_nz;
  logic                               neg;
  logic [pac_pkg::MAG_W-1:0]          mag;
  logic [pac_pkg::DIVD_W-1:0]         prod;
  logic signed [pac_pkg::DELTA_W-1:0] delta;
  pac_pkg::res_t                      res;
  pac_pkg::res_t                      out_res;

  // cursor state
  logic signed [pac_pkg::COORD_W-1:0] cursor_x;
  logic signed [pac_pkg::COORD_W-1:0] cursor_y;
  logic [1:0]                         border_flags;

  // input magnitude and threshold test
  logic signed [pac_pkg::MAG_W-1:0] val_ext;
  logic [pac_pkg::MAG_W-1:0]        mag_in;
  logic                             scale_in;
  logic                             is_delta_in;

  pac_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (cfg.accel_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;

  assign val_ext     = {value[pac_pkg::COORD_W-1], value};
  assign mag_in      = val_ext[pac_pkg::MAG_W-1] ? pac_pkg::MAG_W'(-val_ext)
                                                 : pac_pkg::MAG_W'(val_ext);
  assign scale_in    = mag_in > {2'b00, cfg.accel_thr};
  assign is_delta_in = (kind == pac_pkg::IK_X_DELTA) || (kind == pac_pkg::IK_Y_DELTA);

  // bounding of the selected axis
  logic                               is_x;
  logic signed [pac_pkg::COORD_W-1:0] cur_sel;
  logic signed [pac_pkg::COORD_W-1:0] lo_sel;
  logic signed [pac_pkg::COORD_W-1:0] hi_sel;
  logic                               flag_sel;
  logic signed [pac_pkg::TARGET_W-1:0] cur_ext;
  logic signed [pac_pkg::TARGET_W-1:0] delta_ext;
  logic signed [pac_pkg::TARGET_W-1:0] target;
  logic signed [pac_pkg::TARGET_W-1:0] lo_ext;
  logic signed [pac_pkg::TARGET_W-1:0] hi_ext;
  logic signed [pac_pkg::COORD_W:0]    hi_m1;
  logic signed [pac_pkg::COORD_W:0]    cur_17;
  logic                               drop;
  logic signed [pac_pkg::COORD_W-1:0] cur_new;
  logic                               flag_new;

  assign is_x      = kind_reg == pac_pkg::IK_X_DELTA;
  assign cur_sel   = is_x ? cursor_x : cursor_y;
  assign lo_sel    = is_x ? cfg.x_min : cfg.y_min;
  assign hi_sel    = is_x ? cfg.x_max : cfg.y_max;
  assign flag_sel  = is_x ? border_flags[pac_pkg::FLAG_X] : border_flags[pac_pkg::FLAG_Y];
  assign cur_ext   = {{(pac_pkg::TARGET_W-pac_pkg::COORD_W){cur_sel[pac_pkg::COORD_W-1]}},
                      cur_sel};
  assign delta_ext = {delta[pac_pkg::DELTA_W-1], delta};
  // y motion is inverted
  assign target    = is_x ? cur_ext + delta_ext : cur_ext - delta_ext;
  assign lo_ext    = {{(pac_pkg::TARGET_W-pac_pkg::COORD_W){lo_sel[pac_pkg::COORD_W-1]}},
                      lo_sel};
  assign hi_ext    = {{(pac_pkg::TARGET_W-pac_pkg::COORD_W){hi_sel[pac_pkg::COORD_W-1]}},
                      hi_sel};
  assign hi_m1     = {hi_sel[pac_pkg::COORD_W-1], hi_sel} - 17'sd1;
  assign cur_17    = {cur_sel[pac_pkg::COORD_W-1], cur_sel};

  always_comb begin
    drop     = 1'b0;
    cur_new  = cur_sel;
    flag_new = flag_sel;
    if (target >= hi_ext) begin
      // upper limit is checked first, also for inverted limits
      if (cfg.mode[pac_pkg::MODE_CONFINED]) begin
        drop    = cur_17 == hi_m1;
        cur_new = hi_m1[pac_pkg::COORD_W-1:0];
      end else begin
        drop     = flag_sel;
        cur_new  = hi_sel;
        flag_new = 1'b1;
      end
    end else if (target < lo_ext) begin
      if (cfg.mode[pac_pkg::MODE_CONFINED]) begin
        drop    = cur_sel == lo_sel;
        cur_new = lo_sel;
      end else begin
        drop     = flag_sel;
        cur_new  = -16'sd1;
        flag_new = 1'b1;
      end
    end else begin
      cur_new  = target[pac_pkg::COORD_W-1:0];
      flag_new = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pac_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (is_delta_in) begin
            state_next = scale_in ? pac_pkg::ST_MUL : pac_pkg::ST_BOUND;
          end else begin
            state_next = pac_pkg::ST_EMIT;
          end
        end
      end
      pac_pkg::ST_MUL:    state_next = pac_pkg::ST_DIV_GO;
      pac_pkg::ST_DIV_GO: state_next = pac_pkg::ST_DIV;
      pac_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = pac_pkg::ST_BOUND;
        end
      end
      pac_pkg::ST_BOUND: state_next = drop ? pac_pkg::ST_IDLE : pac_pkg::ST_EMIT;
      pac_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = res.last ? pac_pkg::ST_IDLE : pac_pkg::ST_SET_Y;
        end
      end
      pac_pkg::ST_SET_Y: state_next = pac_pkg::ST_EMIT;
      default: state_next = pac_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    emit_load = 1'b0;
    case (state)
      pac_pkg::ST_IDLE:   in_stall  = 1'b0;
      pac_pkg::ST_DIV_GO: div_start = 1'b1;
      pac_pkg::ST_EMIT:   emit_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture, scaling and result assembly
  always_ff @(posedge clk) begin
    case (state)
      pac_pkg::ST_IDLE: begin
        if (in_acc) begin
          kind_reg <= kind;
          val_nz   <= value != '0;
          neg      <= value[pac_pkg::COORD_W-1];
          mag      <= mag_in;
          delta    <= {{(pac_pkg::DELTA_W-pac_pkg::COORD_W){value[pac_pkg::COORD_W-1]}},
                       value};
          if (kind == pac_pkg::IK_OTHER) begin
            res <= '{out_kind: pac_pkg::OK_OTHER, out_id: event_id, out_value: value,
                     update_cursor: 1'b0, last: 1'b1};
          end else begin
            res <= '{out_kind: pac_pkg::OK_X_ABS, out_id: '0, out_value: pos_x,
                     update_cursor: cfg.mode[pac_pkg::MODE_HW], last: 1'b0};
          end
        end
      end
      pac_pkg::ST_MUL: begin
        prod <= pac_pkg::DIVD_W'(mag) * pac_pkg::DIVD_W'(cfg.accel_num);
      end
      pac_pkg::ST_DIV: begin
        // truncation toward zero: divide the magnitude, then restore the sign
        if (div_done) begin
          if (neg) begin
            delta <= -$signed({1'b0, div_q});
          end else begin
            delta <= $signed({1'b0, div_q});
          end
        end
      end
      pac_pkg::ST_BOUND: begin
        if (val_nz) begin
          res <= '{out_kind: is_x ? pac_pkg::OK_X_ABS : pac_pkg::OK_Y_ABS,
                   out_id: '0, out_value: cur_new,
                   update_cursor: cfg.mode[pac_pkg::MODE_HW], last: 1'b1};
        end else begin
          res <= '{out_kind: is_x ? pac_pkg::OK_X_ZERO : pac_pkg::OK_Y_ZERO,
                   out_id: '0, out_value: '0, update_cursor: 1'b0, last: 1'b1};
        end
      end
      pac_pkg::ST_SET_Y: begin
        res <= '{out_kind: pac_pkg::OK_Y_ABS, out_id: '0, out_value: cursor_y,
                 update_cursor: 1'b0, last: 1'b1};
      end
      default: ;
    endcase
  end

  // cursor position and border flags
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      border_flags <= '0;
    end else if (cfg.limits_wr) begin
      border_flags <= '0;
    end else if (in_acc && kind == pac_pkg::IK_SET_POS) begin
      cursor_x     <= pos_x;
      cursor_y     <= pos_y;
      border_flags <= '0;
    end else if (state == pac_pkg::ST_BOUND && !drop) begin
      if (is_x) begin
        cursor_x                      <= cur_new;
        border_flags[pac_pkg::FLAG_X] <= flag_new;
      end else begin
        cursor_y                      <= cur_new;
        border_flags[pac_pkg::FLAG_Y] <= flag_new;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_res <= res;
    end
  end

  assign out_kind      = out_res.out_kind;
  assign out_id        = out_res.out_id;
  assign out_value     = out_res.out_value;
  assign update_cursor = out_res.update_cursor;
  assign last          = out_res.last;

  // sequencer and datapath checks
  `PAC_ASSERT_NEXT(a_busy_after_accept, in_acc, state != pac_pkg::ST_IDLE, "beat taken but sequencer still idle")
  `PAC_ASSERT_NOW(a_div_done_in_div, div_done, state == pac_pkg::ST_DIV, "divider finished outside the divide state")
  `PAC_ASSERT_NEXT(a_cursor_x_hold, state != pac_pkg::ST_BOUND && !(in_acc && kind == pac_pkg::IK_SET_POS), $stable(cursor_x), "cursor x moved without a bound step or set position")

endmodule

// ===== hdl/pac_regs.sv =====
// configuration register file of the pointer acceleration block
// depends on pac_pkg for cfg_t and the register indexes
module pac_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pac_pkg::CFG_DATA_W-1:0]   cfg_data,
  output pac_pkg::cfg_t                    cfg
);

  logic [pac_pkg::NUM_W-1:0]          accel_num;
  logic [pac_pkg::NUM_W-1:0]          accel_den;
  logic [pac_pkg::THR_W-1:0]          accel_thr;
  logic signed [pac_pkg::COORD_W-1:0] x_min;
  logic signed [pac_pkg::COORD_W-1:0] x_max;
  logic signed [pac_pkg::COORD_W-1:0] y_min;
  logic signed [pac_pkg::COORD_W-1:0] y_max;
  logic [pac_pkg::MODE_W-1:0]         mode;
  logic                               limits_wr;

  // register writes, unused indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_num <= 8'd2;
      accel_den <= 8'd1;
      accel_thr <= 15'd4;
      x_min     <= 16'sd0;
      x_max     <= 16'sd1024;
      y_min     <= 16'sd0;
      y_max     <= 16'sd768;
      mode      <= 2'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        pac_pkg::REG_ACCEL_NUM: accel_num <= cfg_data[pac_pkg::NUM_W-1:0];
        pac_pkg::REG_ACCEL_DEN: begin
          // a zero divisor is stored as one
          if (cfg_data[pac_pkg::NUM_W-1:0] == '0) begin
            accel_den <= 8'd1;
          end else begin
            accel_den <= cfg_data[pac_pkg::NUM_W-1:0];
          end
        end
        pac_pkg::REG_ACCEL_THR: accel_thr <= cfg_data[pac_pkg::THR_W-1:0];
        pac_pkg::REG_X_MIN:     x_min     <= $signed(cfg_data);
        pac_pkg::REG_X_MAX:     x_max     <= $signed(cfg_data);
        pac_pkg::REG_Y_MIN:     y_min     <= $signed(cfg_data);
        pac_pkg::REG_Y_MAX:     y_max     <= $signed(cfg_data);
        pac_pkg::REG_MODE:      mode      <= cfg_data[pac_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // any limit write clears the border flags
  always_comb begin
    limits_wr = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        pac_pkg::REG_X_MIN, pac_pkg::REG_X_MAX,
        pac_pkg::REG_Y_MIN, pac_pkg::REG_Y_MAX: limits_wr = 1'b1;
        default: limits_wr = 1'b0;
      endcase
    end
  end

  assign cfg = '{accel_num: accel_num, accel_den: accel_den, accel_thr: accel_thr,
                 x_min: x_min, x_max: x_max, y_min: y_min, y_max: y_max,
                 mode: mode, limits_wr: limits_wr};

endmodule

// ===== hdl/pac_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on pac_pkg for the dividend and divisor widths
module pac_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pac_pkg::DIVD_W-1:0]  dividend,
  input  logic [pac_pkg::NUM_W-1:0]   divisor,
  output logic                        done,
  output logic [pac_pkg::DIVD_W-1:0]  quotient
);

  logic                           busy;
  logic [pac_pkg::DIV_CNT_W-1:0]  count;
  logic [pac_pkg::NUM_W-1:0]      den;
  logic [pac_pkg::NUM_W-1:0]      rem;
  logic [pac_pkg::DIVD_W-1:0]     quo;
  logic [pac_pkg::NUM_W:0]        rem_sh;
  logic                           fits;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem, quo[pac_pkg::DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == pac_pkg::DIV_CNT_W'(pac_pkg::DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= pac_pkg::NUM_W'(rem_sh - {1'b0, den});
      end else begin
        rem <= rem_sh[pac_pkg::NUM_W-1:0];
      end
      quo <= {quo[pac_pkg::DIVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== tb/sv/pointer_accel_cursor_clamp_test.sv =====
// self-checking bench for the pointer acceleration and cursor clamp block
// drives the input, config and output ports of pointer_accel_cursor_clamp and predicts
// every result beat from its own cursor model or from a typed row; needs pac_pkg
module pointer_accel_cursor_clamp_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pac_pkg::*;

  // run shape
  localparam int RANDOM_ITEMS  = 800;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTS    = 100;

  // register indexes past the last real one, and mode bit patterns
  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = 4'd15;
  localparam logic [CFG_DATA_W-1:0] MODE_BITS_CONF = 16'(1 << MODE_CONFINED);
  localparam logic [CFG_DATA_W-1:0] MODE_BITS_HW   = 16'(1 << MODE_HW);

  // one row of stimulus: a register write or an input beat, with optional typed results
  typedef struct packed {
    logic                      is_cfg;
    logic [CFG_IDX_W-1:0]      reg_sel;
    logic [CFG_DATA_W-1:0]     reg_data;
    in_kind_t                  k;
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] val;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      typed;
    logic [1:0]                nres;
    res_t                      b0;
    res_t                      b1;
  } plan_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  kind = '0;
  logic [ID_W-1:0]             event_id = '0;
  logic signed [COORD_W-1:0]   value = '0;
  logic signed [COORD_W-1:0]   pos_x = '0;
  logic signed [COORD_W-1:0]   pos_y = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [2:0]                  out_kind;
  logic [ID_W-1:0]             out_id;
  logic signed [COORD_W-1:0]   out_value;
  logic                        update_cursor;
  logic                        last;

  // cursor model: configuration copy and cursor state
  int         acc_num, acc_den, acc_thr;
  int         lim_x_lo, lim_x_hi, lim_y_lo, lim_y_hi;
  logic [1:0] op_mode;
  int         cur_x, cur_y;
  logic [1:0] border_hit;

  res_t       cursor_reports[$];
  int         bad_beats = 0;
  bit         hold_req = 1'b0;
  bit         quiet = 1'b0;
  int         burst_left = 0;
  plan_row_t  plan[$];

  pointer_accel_cursor_clamp u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .event_id(event_id), .value(value), .pos_x(pos_x), .pos_y(pos_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_id(out_id), .out_value(out_value),
    .update_cursor(update_cursor), .last(last)
  );

  // clock, 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit: reports failure and stops if the run has not finished
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic note_mismatch(input string what);
    if (bad_beats < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
    bad_beats++;
  endtask

  function automatic res_t beat(input out_kind_t k, input logic [ID_W-1:0] id,
                                input logic [COORD_W-1:0] v, input logic upd,
                                input logic fin);
    res_t b;
    b.out_kind      = k;
    b.out_id        = id;
    b.out_value     = v;
    b.update_cursor = upd;
    b.last          = fin;
    return b;
  endfunction

  function automatic int wrap16(input int x);
    logic signed [COORD_W-1:0] t;
    t = x[COORD_W-1:0];
    return int'(t);
  endfunction

  // register state after reset
  function automatic void mirror_reset();
    acc_num = 2;
    acc_den = 1;
    acc_thr = 4;
    lim_x_lo = 0;
    lim_x_hi = 1024;
    lim_y_lo = 0;
    lim_y_hi = 768;
    op_mode = '0;
    cur_x = 0;
    cur_y = 0;
    border_hit = '0;
  endfunction

  function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] sel,
                                     input logic [CFG_DATA_W-1:0] data);
    case (sel)
      REG_ACCEL_NUM: acc_num = int'(data[NUM_W-1:0]);
      REG_ACCEL_DEN: acc_den = (data[NUM_W-1:0] == '0) ? 1 : int'(data[NUM_W-1:0]);
      REG_ACCEL_THR: acc_thr = int'(data[THR_W-1:0]);
      REG_X_MIN: begin
        lim_x_lo = int'($signed(data));
        border_hit = '0;
      end
      REG_X_MAX: begin
        lim_x_hi = int'($signed(data));
        border_hit = '0;
      end
      REG_Y_MIN: begin
        lim_y_lo = int'($signed(data));
        border_hit = '0;
      end
      REG_Y_MAX: begin
        lim_y_hi = int'($signed(data));
        border_hit = '0;
      end
      REG_MODE: op_mode = data[MODE_W-1:0];
      default: ;
    endcase
  endfunction

  // scale large deltas by num/den, truncating toward zero
  function automatic int accel_delta(input int d);
    int mag;
    mag = (d < 0) ? -d : d;
    if (mag > acc_thr) return (d * acc_num) / acc_den;
    return d;
  endfunction

  // bound one axis; zero means the beat is dropped
  function automatic bit clamp_axis(inout int cur, input int target, input int lo,
                                    input int hi, input int flag);
    if (target >= hi) begin
      if (op_mode[MODE_CONFINED]) begin
        if (cur == hi - 1) return 1'b0;
        cur = wrap16(hi - 1);
      end else begin
        if (border_hit[flag]) return 1'b0;
        cur = hi;
        border_hit[flag] = 1'b1;
      end
    end else if (target < lo) begin
      if (op_mode[MODE_CONFINED]) begin
        if (cur == lo) return 1'b0;
        cur = lo;
      end else begin
        if (border_hit[flag]) return 1'b0;
        cur = -1;
        border_hit[flag] = 1'b1;
      end
    end else begin
      cur = target;
      border_hit[flag] = 1'b0;
    end
    return 1'b1;
  endfunction

  // move the cursor for one input beat and work out its result beats
  function automatic int advance_cursor(input in_kind_t k, input logic [ID_W-1:0] id,
                                        input logic signed [COORD_W-1:0] v,
                                        input logic signed [COORD_W-1:0] px,
                                        input logic signed [COORD_W-1:0] py,
                                        output res_t b0, output res_t b1);
    int  d;
    bit  keep;
    bit  is_x;
    logic hw;
    b0 = '0;
    b1 = '0;
    hw = op_mode[MODE_HW];
    is_x = (k == IK_X_DELTA);
    case (k)
      IK_X_DELTA, IK_Y_DELTA: begin
        d = accel_delta(int'(v));
        if (is_x) keep = clamp_axis(cur_x, cur_x + d, lim_x_lo, lim_x_hi, FLAG_X);
        else      keep = clamp_axis(cur_y, cur_y - d, lim_y_lo, lim_y_hi, FLAG_Y);
        if (!keep) return 0;
        if (v != 0)
          b0 = beat(is_x ? OK_X_ABS : OK_Y_ABS, '0, 16'(is_x ? cur_x : cur_y), hw, 1'b1);
        else
          b0 = beat(is_x ? OK_X_ZERO : OK_Y_ZERO, '0, '0, 1'b0, 1'b1);
        return 1;
      end
      IK_OTHER: begin
        b0 = beat(OK_OTHER, id, v, 1'b0, 1'b1);
        return 1;
      end
      default: begin
        cur_x = int'(px);
        cur_y = int'(py);
        border_hit = '0;
        b0 = beat(OK_X_ABS, '0, px, hw, 1'b0);
        b1 = beat(OK_Y_ABS, '0, py, 1'b0, 1'b1);
        return 2;
      end
    endcase
  endfunction

  // stimulus rows
  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_sel = sel;
    r.reg_data = data;
    return r;
  endfunction

  function automatic plan_row_t item_row(input in_kind_t k, input logic [ID_W-1:0] id,
                                         input logic [COORD_W-1:0] v,
                                         input logic [COORD_W-1:0] px,
                                         input logic [COORD_W-1:0] py);
    plan_row_t r;
    r = '0;
    r.k = k;
    r.id = id;
    r.val = v;
    r.px = px;
    r.py = py;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input in_kind_t k, input logic [ID_W-1:0] id,
                                          input logic [COORD_W-1:0] v,
                                          input logic [COORD_W-1:0] px,
                                          input logic [COORD_W-1:0] py,
                                          input logic [1:0] n, input res_t b0,
                                          input res_t b1);
    plan_row_t r;
    r = item_row(k, id, v, px, py);
    r.typed = 1'b1;
    r.nres = n;
    r.b0 = b0;
    r.b1 = b1;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] one_of(input logic [CFG_DATA_W-1:0] a,
                                                   input logic [CFG_DATA_W-1:0] b,
                                                   input logic [CFG_DATA_W-1:0] c,
                                                   input logic [CFG_DATA_W-1:0] d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  // coordinate close to a limit, sometimes anywhere
  function automatic logic [COORD_W-1:0] near_limit(input int lo, input int hi);
    int pick;
    pick = int'($urandom_range(0, 9));
    if (pick < 4) return 16'(lo + int'($urandom_range(0, 8)) - 4);
    if (pick < 8) return 16'(hi + int'($urandom_range(0, 8)) - 4);
    return 16'($urandom);
  endfunction

  function automatic plan_row_t rand_row();
    int       pick, v;
    in_kind_t k;
    pick = int'($urandom_range(0, 99));
    if (pick < 36)      k = IK_X_DELTA;
    else if (pick < 72) k = IK_Y_DELTA;
    else if (pick < 86) k = IK_OTHER;
    else                k = IK_SET_POS;
    pick = int'($urandom_range(0, 99));
    if (pick < 55)      v = int'($urandom_range(0, 16)) - 8;
    else if (pick < 80) v = int'($urandom_range(0, 600)) - 300;
    else if (pick < 95) v = int'($urandom);
    else                v = int'($signed(one_of(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF)));
    return item_row(k, 16'($urandom), 16'(v), near_limit(lim_x_lo, lim_x_hi),
                    near_limit(lim_y_lo, lim_y_hi));
  endfunction

  // sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (quiet) return 0;
    pick = int'($urandom_range(0, 99));
    if (pick < 55) return 0;
    if (pick < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 60));
  endfunction

  // offer one input beat and hold it until taken, then predict its results
  task automatic offer(input plan_row_t r);
    res_t p0, p1;
    int   n;
    @(negedge clk);
    in_valid <= 1'b1;
    kind     <= r.k;
    event_id <= r.id;
    value    <= r.val;
    pos_x    <= r.px;
    pos_y    <= r.py;
    do @(posedge clk); while (in_stall);
    n = advance_cursor(r.k, r.id, r.val, r.px, r.py, p0, p1);
    if (r.typed) begin
      n = int'(r.nres);
      p0 = r.b0;
      p1 = r.b1;
    end
    if (n > 0) cursor_reports.push_back(p0);
    if (n > 1) cursor_reports.push_back(p1);
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // stop sending and wait for every predicted beat
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk);
  endtask

  // drain, then let a dropped delta still in the divider finish
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    mirror_reg(sel, data);
  endtask

  // one axis pair of limits: mostly sane, sometimes extreme or inverted
  task automatic write_limits(input logic [CFG_IDX_W-1:0] lo_sel,
                              input logic [CFG_IDX_W-1:0] hi_sel);
    int lo, pick;
    pick = int'($urandom_range(0, 99));
    if (pick < 70) begin
      lo = int'($urandom_range(0, 400)) - 200;
      write_reg(lo_sel, 16'(lo));
      write_reg(hi_sel, 16'(lo + int'($urandom_range(1, 1200))));
    end else if (pick < 85) begin
      write_reg(lo_sel, one_of(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
      write_reg(hi_sel, one_of(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
    end else begin
      write_reg(lo_sel, 16'($urandom));
      write_reg(hi_sel, 16'($urandom));
    end
  endtask

  // new random setting of every register
  task automatic shuffle_config();
    write_reg(REG_ACCEL_NUM, one_of(16'h0000, 16'h00FF, 16'($urandom_range(1, 8)),
                                    16'($urandom)));
    write_reg(REG_ACCEL_DEN, one_of(16'hFF00, 16'h00FF, 16'($urandom_range(1, 6)),
                                    16'($urandom)));
    write_reg(REG_ACCEL_THR, one_of(16'h0000, 16'h7FFF, 16'($urandom_range(0, 40)),
                                    16'($urandom)));
    write_limits(REG_X_MIN, REG_X_MAX);
    write_limits(REG_Y_MIN, REG_Y_MAX);
    write_reg(REG_MODE, one_of(16'h0000, MODE_BITS_CONF, MODE_BITS_HW,
                               MODE_BITS_CONF | MODE_BITS_HW) | (16'($urandom) & 16'hFFFC));
    if ($urandom_range(0, 2) == 0)
      write_reg(4'(int'(REG_SPARE) + int'($urandom_range(0, 7))), 16'($urandom));
  endtask

  // receiver: random stall bursts, quiet stretches, and one long hold on request
  initial begin : out_side
    int n, pick;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (quiet) begin
        out_stall <= 1'b0;
        n = 1;
      end else begin
        pick = int'($urandom_range(0, 99));
        if (pick < 65) begin
          out_stall <= 1'b0;
          n = int'($urandom_range(1, 4));
        end else if (pick < 94) begin
          out_stall <= 1'b1;
          n = int'($urandom_range(1, 3));
        end else begin
          out_stall <= 1'b1;
          n = int'($urandom_range(8, 40));
        end
      end
      repeat (n) @(negedge clk);
    end
  end

  // compare each taken result beat with the oldest prediction
  always @(posedge clk) begin : beat_check
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (cursor_reports.size() == 0) begin
        note_mismatch($sformatf("unpredicted beat kind %0d id %0h value %0d",
                                out_kind, out_id, out_value));
      end else begin
        want = cursor_reports.pop_front();
        if (out_kind !== want.out_kind)
          note_mismatch($sformatf("out_kind %0d, predicted %0d", out_kind, want.out_kind));
        if (out_id !== want.out_id)
          note_mismatch($sformatf("out_id %0h, predicted %0h", out_id, want.out_id));
        if (out_value !== want.out_value)
          note_mismatch($sformatf("out_value %0d, predicted %0d", out_value,
                                  $signed(want.out_value)));
        if (update_cursor !== want.update_cursor)
          note_mismatch($sformatf("update_cursor %b, predicted %b", update_cursor,
                                  want.update_cursor));
        if (last !== want.last)
          note_mismatch($sformatf("last %b, predicted %b", last, want.last));
      end
    end
  end

  initial begin : stimulus
    bit busy;
    mirror_reset();

    // reset config: unconfined, num 2, den 1, threshold 4, x [0,1024), y [0,768)
    plan.push_back(typed_row(IK_OTHER, 16'hFFFF, 16'h8000, '0, '0, 2'd1,
                             beat(OK_OTHER, 16'hFFFF, 16'h8000, 1'b0, 1'b1), '0));
    plan.push_back(typed_row(IK_OTHER, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 2'd1,
                             beat(OK_OTHER, 16'h0000, 16'h7FFF, 1'b0, 1'b1), '0));
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'd3, '0, '0, 2'd1,
                             beat(OK_X_ABS, '0, 16'd3, 1'b0, 1'b1), '0));
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'd0, '0, '0, 2'd1,
                             beat(OK_X_ZERO, '0, 16'd0, 1'b0, 1'b1), '0));
    // just above threshold: doubled
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'd5, '0, '0, 2'd1,
                             beat(OK_X_ABS, '0, 16'd13, 1'b0, 1'b1), '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'hFFFB, '0, '0));
    // run off the right edge, then further pushes are dropped
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'h7FFF, '0, '0, 2'd1,
                             beat(OK_X_ABS, '0, 16'd1024, 1'b0, 1'b1), '0));
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'd1, '0, '0, 2'd0, '0, '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'h8000, '0, '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'hFFFC, '0, '0));
    // y is inverted: positive delta goes below y_min
    plan.push_back(typed_row(IK_Y_DELTA, '0, 16'd3, '0, '0, 2'd1,
                             beat(OK_Y_ABS, '0, 16'hFFFF, 1'b0, 1'b1), '0));
    plan.push_back(item_row(IK_Y_DELTA, '0, 16'd0, '0, '0));
    plan.push_back(item_row(IK_Y_DELTA, '0, 16'hFFFE, '0, '0));
    plan.push_back(typed_row(IK_SET_POS, '0, '0, 16'h8000, 16'h7FFF, 2'd2,
                             beat(OK_X_ABS, '0, 16'h8000, 1'b0, 1'b0),
                             beat(OK_Y_ABS, '0, 16'h7FFF, 1'b0, 1'b1)));
    plan.push_back(item_row(IK_Y_DELTA, '0, 16'h8000, '0, '0));

    // confined with cursor updates, num 255, den write of zero
    plan.push_back(cfg_row(REG_MODE, MODE_BITS_CONF | MODE_BITS_HW));
    plan.push_back(cfg_row(REG_ACCEL_NUM, 16'hFFFF));
    plan.push_back(cfg_row(REG_ACCEL_DEN, 16'hFF00));
    plan.push_back(typed_row(IK_SET_POS, '0, '0, 16'd0, 16'd0, 2'd2,
                             beat(OK_X_ABS, '0, 16'd0, 1'b1, 1'b0),
                             beat(OK_Y_ABS, '0, 16'd0, 1'b0, 1'b1)));
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'h7FFF, '0, '0, 2'd1,
                             beat(OK_X_ABS, '0, 16'd1023, 1'b1, 1'b1), '0));
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'd100, '0, '0, 2'd0, '0, '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'd0, '0, '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'h8000, '0, '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'hFFFF, '0, '0));
    plan.push_back(item_row(IK_Y_DELTA, '0, 16'd1, '0, '0));
    plan.push_back(item_row(IK_Y_DELTA, '0, 16'hFFFF, '0, '0));

    // inverted x limits with x_max at the most negative value, num 0, max threshold
    plan.push_back(cfg_row(REG_ACCEL_THR, 16'hFFFF));
    plan.push_back(cfg_row(REG_ACCEL_NUM, 16'h0000));
    plan.push_back(cfg_row(REG_ACCEL_DEN, 16'h00FF));
    plan.push_back(cfg_row(REG_X_MIN, 16'd100));
    plan.push_back(cfg_row(REG_X_MAX, 16'h8000));
    plan.push_back(cfg_row(REG_MODE, MODE_BITS_CONF));
    plan.push_back(cfg_row(REG_SPARE, 16'h00FF));
    plan.push_back(cfg_row(REG_SPARE_LAST, 16'h0000));
    plan.push_back(typed_row(IK_X_DELTA, '0, 16'd5, '0, '0, 2'd1,
                             beat(OK_X_ABS, '0, 16'h7FFF, 1'b0, 1'b1), '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'h8000, '0, '0));
    plan.push_back(item_row(IK_X_DELTA, '0, 16'd0, '0, '0));
    plan.push_back(item_row(IK_Y_DELTA, '0, 16'h8000, '0, '0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    busy = 1'b0;
    foreach (plan[j]) begin
      if (plan[j].is_cfg) begin
        if (busy) settle();
        busy = 1'b0;
        write_reg(plan[j].reg_sel, plan[j].reg_data);
      end else begin
        offer(plan[j]);
        busy = 1'b1;
        idle_in(pick_gap());
      end
    end

    // random phases, each under a fresh register setting
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        settle();
        shuffle_config();
      end
      // long receiver hold while beats keep coming back to back
      if (i == 150) begin
        hold_req = 1'b1;
        burst_left = 24;
      end
      quiet = (i >= 400 && i < 480);
      offer(rand_row());
      if ($urandom_range(0, 49) == 0) drain();
      else idle_in(pick_gap());
    end

    settle();
    if (bad_beats == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
